>>> rtl/frr_pkg.sv
`default_nettype none
package frr_pkg;

   localparam logic [7:0] MAGIC_A       = 8'h4d;
   localparam logic [7:0] MAGIC_B       = 8'h4c;
   localparam logic [7:0] FRAME_VERSION = 8'h01;

   localparam logic [7:0] POS_MAGIC_A = 8'd0;
   localparam logic [7:0] POS_MAGIC_B = 8'd1;
   localparam logic [7:0] POS_VERSION = 8'd2;
   localparam logic [7:0] POS_INDEX   = 8'd3;
   localparam logic [7:0] POS_COUNT   = 8'd4;
   localparam logic [7:0] POS_LEN_HI  = 8'd5;
   localparam logic [7:0] POS_LEN_LO  = 8'd6;

   localparam logic OP_FRAME = 1'b0;
   localparam logic OP_PULL  = 1'b1;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_BYTE   = 1'b1;

   typedef enum logic [2:0] {
      ST_STORED       = 3'd0,
      ST_COMPLETE     = 3'd1,
      ST_BAD_FRAME    = 3'd2,
      ST_DUP_MISMATCH = 3'd3,
      ST_TOO_LARGE    = 3'd4,
      ST_NO_PACKET    = 3'd5
   } frr_status_type;

   // what the parser reports for the current beat, including the end-of-frame verdict
   typedef struct packed {
      logic        bad;
      logic [7:0]  idx;
      logic [7:0]  cnt;
      logic [15:0] plen;
      logic [63:0] id;
      logic        pay_we;
      logic [7:0]  pay_off;
   } frr_parse_type;

endpackage
`default_nettype wire

>>> rtl/frr_req_if.sv
`default_nettype none
interface frr_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] data_byte;
   logic       frame_end;

   modport source (output valid, output operation, output data_byte, output frame_end,
                   input ready);
   modport sink (input valid, input operation, input data_byte, input frame_end,
                 output ready);
endinterface
`default_nettype wire

>>> rtl/frr_rsp_if.sv
`default_nettype none
interface frr_rsp_if;
   logic       valid;
   logic       ready;
   logic       result_kind;
   logic [2:0] status;
   logic [7:0] packet_byte;
   logic [9:0] packet_length;
   logic       last_byte;

   modport source (output valid, output result_kind, output status, output packet_byte,
                   output packet_length, output last_byte, input ready);
   modport sink (input valid, input result_kind, input status, input packet_byte,
                 input packet_length, input last_byte, output ready);
endinterface
`default_nettype wire

>>> rtl/frr_parser.sv
`default_nettype none
module frr_parser #(
   parameter int ID_BYTES          = 8,
   parameter int MAX_FRAME_BYTES   = 255,
   parameter int MAX_PAYLOAD_BYTES = 240,
   parameter int MAX_FRAGMENTS     = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 take,
   input  wire logic [7:0]           data_byte,
   input  wire logic                 frame_end,
   output frr_pkg::frr_parse_type    parse
);

   localparam int HDR = 7 + ID_BYTES;

   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  idx_ff, idx_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic [15:0] plen_ff, plen_in;
   logic [63:0] id_ff, id_in;
   logic        bad_head_ff, bad_head_in;
   logic        too_long_ff, too_long_in;
   logic        pay_we;
   logic [7:0]  pay_off;

   always_comb begin
      pos_in      = pos_ff;
      idx_in      = idx_ff;
      cnt_in      = cnt_ff;
      plen_in     = plen_ff;
      id_in       = id_ff;
      bad_head_in = bad_head_ff;
      too_long_in = too_long_ff;
      pay_we      = 1'b0;
      pay_off     = 8'd0;
      if (pos_ff >= 8'(MAX_FRAME_BYTES)) begin
         too_long_in = 1'b1;
      end else begin
         pos_in = pos_ff + 8'd1;
         if ((pos_ff == frr_pkg::POS_MAGIC_A && data_byte != frr_pkg::MAGIC_A) ||
             (pos_ff == frr_pkg::POS_MAGIC_B && data_byte != frr_pkg::MAGIC_B) ||
             (pos_ff == frr_pkg::POS_VERSION && data_byte != frr_pkg::FRAME_VERSION)) begin
            bad_head_in = 1'b1;
         end else if (pos_ff == frr_pkg::POS_INDEX) begin
            idx_in = data_byte;
         end else if (pos_ff == frr_pkg::POS_COUNT) begin
            cnt_in = data_byte;
         end else if (pos_ff == frr_pkg::POS_LEN_HI) begin
            plen_in[15:8] = data_byte;
         end else if (pos_ff == frr_pkg::POS_LEN_LO) begin
            plen_in[7:0] = data_byte;
         end else if (pos_ff < 8'(HDR)) begin
            // good magic and version bytes also shift through the id
            id_in = {id_ff[55:0], data_byte};
         end else if (pos_ff - 8'(HDR) < 8'(MAX_PAYLOAD_BYTES)) begin
            pay_we  = 1'b1;
            pay_off = pos_ff - 8'(HDR);
         end
      end
   end

   always_comb begin
      parse.idx     = idx_in;
      parse.cnt     = cnt_in;
      parse.plen    = plen_in;
      parse.id      = id_in;
      parse.pay_we  = pay_we;
      parse.pay_off = pay_off;
      parse.bad     = bad_head_in || too_long_in || pos_in < 8'(HDR) || cnt_in == 8'd0 ||
                      cnt_in > 8'(MAX_FRAGMENTS) || idx_in >= cnt_in ||
                      plen_in > 16'(MAX_PAYLOAD_BYTES) ||
                      {8'd0, pos_in} != 16'(HDR) + plen_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (take && frame_end)) begin
         pos_ff      <= 8'd0;
         idx_ff      <= 8'd0;
         cnt_ff      <= 8'd0;
         plen_ff     <= 16'd0;
         id_ff       <= 64'd0;
         bad_head_ff <= 1'b0;
         too_long_ff <= 1'b0;
      end else if (take) begin
         pos_ff      <= pos_in;
         idx_ff      <= idx_in;
         cnt_ff      <= cnt_in;
         plen_ff     <= plen_in;
         id_ff       <= id_in;
         bad_head_ff <= bad_head_in;
         too_long_ff <= too_long_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/frr_store.sv
`default_nettype none
module frr_store #(
   parameter int AW = 13
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic [7:0]         rd_data
);

   logic [7:0] mem [(1 << AW)];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> rtl/fragment_frame_reassembler_core.sv
// Fragment frame reassembler.
// req_chan (valid/ready) carries one beat per item: operation 0 is a frame byte, with
// frame_end on the last byte of a frame; operation 1 pulls the next byte of the joined
// packet. rsp_chan returns a status beat for each frame end and a byte beat for each pull;
// other frame bytes return nothing. csr_write_enable/csr_write_data set the packet buffer
// size (reset 512).
// An accepted beat passes stage 1, then the output register, to rsp_chan valid. One beat
// is taken per cycle unless rsp_chan stalls; the beat after a frame end waits for the commit.
// Payload bytes go straight into a two-bank fragment memory (one write, one read port):
// a new fragment lands in the spare bank of its slot and the slot flips at frame end, and
// a repeat is compared against the live bank as it streams in.
// Reset clears the message and parser state; memory contents need no clearing.
// When rsp_chan stalls, the output register and the stage behind it hold, and req_chan
// ready drops until the result is taken.
`default_nettype none
module fragment_frame_reassembler_core #(
   parameter int MAX_FRAGMENTS     = 16,
   parameter int ID_BYTES          = 8,
   parameter int MAX_FRAME_BYTES   = 255,
   parameter int MAX_PAYLOAD_BYTES = 240,
   parameter int PACKET_MTU        = 512
) (
   input  wire logic       clock,
   input  wire logic       reset,
   frr_req_if.sink         req_chan,
   frr_rsp_if.source       rsp_chan,
   input  wire logic       csr_write_enable,
   input  wire logic [9:0] csr_write_data
);

   localparam int FW  = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
   localparam int OW  = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;
   localparam int NF2 = 1 << FW;
   localparam int AW  = 1 + FW + OW;

   frr_pkg::frr_parse_type parse;

   logic       adv, take, take_frame, take_pull;
   logic [9:0] buf_size_ff;

   // message state
   logic           active_ff;
   logic [7:0]     exp_cnt_ff;
   logic [63:0]    act_id_ff;
   logic [NF2-1:0] map_ff;
   logic [NF2-1:0] bank_ff;
   logic [NF2-1:0] nz_ff;
   logic [7:0]     len_ff [NF2];
   logic [7:0]     rtot_ff;
   logic [15:0]    total_ff;
   logic           pready_ff;
   logic [9:0]     rptr_ff;
   logic [FW-1:0]  rd_frag_ff;
   logic [OW-1:0]  rd_off_ff;
   logic           dup_bad_ff;

   // stage 1
   logic           s1_valid_ff, s1_pull_ff, s1_end_ff, s1_cmp_ff;
   logic [7:0]     s1_byte_ff;
   logic           s1_bad_ff, s1_new_ff, s1_dup_ff, s1_lenmis_ff;
   logic [FW-1:0]  s1_idx_ff;
   logic [7:0]     s1_cnt_ff;
   logic [7:0]     s1_plen_ff;
   logic [63:0]    s1_id_ff;
   logic           s1_ok_ff, s1_last_ff;
   logic [9:0]     s1_total_ff;

   // output register
   logic       rsp_valid_ff, rsp_kind_ff, rsp_last_ff;
   logic [2:0] rsp_status_ff;
   logic [7:0] rsp_byte_ff;
   logic [9:0] rsp_len_ff;

   logic          same_msg, cmp_en, pay_we;
   logic [FW-1:0] fidx;
   logic [OW-1:0] foff;
   logic [7:0]    rd_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          pull_last;
   logic [FW-1:0] next_nz;
   logic          off_wrap;

   assign adv        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv && !(s1_valid_ff && s1_end_ff);
   assign take       = req_chan.valid && req_chan.ready;
   assign take_frame = take && req_chan.operation == frr_pkg::OP_FRAME;
   assign take_pull  = take && req_chan.operation == frr_pkg::OP_PULL;

   frr_parser #(
      .ID_BYTES          (ID_BYTES),
      .MAX_FRAME_BYTES   (MAX_FRAME_BYTES),
      .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES),
      .MAX_FRAGMENTS     (MAX_FRAGMENTS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .take      (take_frame),
      .data_byte (req_chan.data_byte),
      .frame_end (req_chan.frame_end),
      .parse     (parse)
   );

   assign fidx     = parse.idx[FW-1:0];
   assign foff     = parse.pay_off[OW-1:0];
   assign same_msg = active_ff && exp_cnt_ff == parse.cnt && act_id_ff == parse.id;
   assign pay_we   = take_frame && parse.pay_we;
   assign cmp_en   = pay_we && same_msg && map_ff[fidx];
   assign rd_en    = cmp_en || (take_pull && pready_ff);
   assign rd_addr  = take_pull ? {bank_ff[rd_frag_ff], rd_frag_ff, rd_off_ff}
                               : {bank_ff[fidx], fidx, foff};
   assign pull_last = {6'd0, rptr_ff} + 16'd1 >= total_ff;
   assign off_wrap  = 8'(rd_off_ff) + 8'd1 == len_ff[rd_frag_ff];

   frr_store #(.AW(AW)) u_store (
      .clock   (clock),
      .wr_en   (pay_we),
      .wr_addr ({~bank_ff[fidx], fidx, foff}),
      .wr_data (req_chan.data_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      next_nz = rd_frag_ff;
      for (int i = NF2 - 1; i >= 0; i--) begin
         if (nz_ff[i] && i > int'(rd_frag_ff)) begin
            next_nz = FW'(i);
         end
      end
   end

   // frame commit
   logic                  mism_now, c_store, c_dupbad, c_complete, c_large;
   logic [7:0]            c_rt;
   logic [15:0]           c_tot;
   logic [NF2-1:0]        c_map, c_nz, c_bank;
   logic [FW-1:0]         c_first;
   frr_pkg::frr_status_type c_status;

   always_comb begin
      mism_now = s1_cmp_ff && rd_data != s1_byte_ff;
      c_dupbad = s1_dup_ff && (s1_lenmis_ff || dup_bad_ff || mism_now);
      c_store  = !s1_dup_ff;
      c_map    = s1_new_ff ? '0 : map_ff;
      c_nz     = s1_new_ff ? '0 : nz_ff;
      c_bank   = bank_ff;
      c_rt     = s1_new_ff ? 8'd0 : rtot_ff;
      c_tot    = s1_new_ff ? 16'd0 : total_ff;
      if (c_store) begin
         c_map[s1_idx_ff]  = 1'b1;
         c_nz[s1_idx_ff]   = s1_plen_ff != 8'd0;
         c_bank[s1_idx_ff] = ~bank_ff[s1_idx_ff];
         c_rt              = c_rt + 8'd1;
         c_tot             = c_tot + {8'd0, s1_plen_ff};
      end
      c_complete = c_rt == s1_cnt_ff;
      c_large    = c_tot > 16'(PACKET_MTU) || c_tot > {6'd0, buf_size_ff};
      c_first    = '0;
      for (int i = NF2 - 1; i >= 0; i--) begin
         if (c_nz[i]) begin
            c_first = FW'(i);
         end
      end
      if (s1_bad_ff) begin
         c_status = frr_pkg::ST_BAD_FRAME;
      end else if (c_dupbad) begin
         c_status = frr_pkg::ST_DUP_MISMATCH;
      end else if (!c_complete) begin
         c_status = frr_pkg::ST_STORED;
      end else if (c_large) begin
         c_status = frr_pkg::ST_TOO_LARGE;
      end else begin
         c_status = frr_pkg::ST_COMPLETE;
      end
   end

   logic commit, apply;
   assign commit = adv && s1_valid_ff && !s1_pull_ff && s1_end_ff;
   assign apply  = commit && !s1_bad_ff && !c_dupbad;

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_size_ff <= 10'd512;
      end else if (csr_write_enable) begin
         buf_size_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         exp_cnt_ff <= 8'd0;
         act_id_ff  <= 64'd0;
         map_ff     <= '0;
         nz_ff      <= '0;
         bank_ff    <= '0;
         rtot_ff    <= 8'd0;
         total_ff   <= 16'd0;
         pready_ff  <= 1'b0;
         rptr_ff    <= 10'd0;
         rd_frag_ff <= '0;
         rd_off_ff  <= '0;
         dup_bad_ff <= 1'b0;
      end else begin
         if (adv && s1_valid_ff && !s1_pull_ff) begin
            dup_bad_ff <= s1_end_ff ? 1'b0 : (dup_bad_ff || mism_now);
         end
         if (apply) begin
            active_ff  <= 1'b1;
            exp_cnt_ff <= s1_cnt_ff;
            act_id_ff  <= s1_id_ff;
            map_ff     <= c_map;
            nz_ff      <= c_nz;
            bank_ff    <= c_bank;
            rtot_ff    <= c_rt;
            total_ff   <= c_tot;
            if (s1_new_ff) begin
               pready_ff <= 1'b0;
               rptr_ff   <= 10'd0;
            end
            if (c_complete) begin
               pready_ff <= !c_large && c_tot != 16'd0;
               if (!c_large) begin
                  rptr_ff    <= 10'd0;
                  rd_frag_ff <= c_first;
                  rd_off_ff  <= '0;
               end
            end
         end else if (take_pull && pready_ff) begin
            rptr_ff <= rptr_ff + 10'd1;
            if (pull_last) begin
               pready_ff <= 1'b0;
            end
            // hop over empty fragments to the next one that holds bytes
            if (off_wrap) begin
               rd_frag_ff <= next_nz;
               rd_off_ff  <= '0;
            end else begin
               rd_off_ff <= rd_off_ff + OW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_pull_ff   <= take_pull;
         s1_end_ff    <= req_chan.frame_end;
         s1_cmp_ff    <= cmp_en;
         s1_byte_ff   <= req_chan.data_byte;
         s1_bad_ff    <= parse.bad;
         s1_new_ff    <= !same_msg;
         s1_dup_ff    <= same_msg && map_ff[fidx];
         s1_lenmis_ff <= {8'd0, len_ff[fidx]} != parse.plen;
         s1_idx_ff    <= fidx;
         s1_cnt_ff    <= parse.cnt;
         s1_plen_ff   <= parse.plen[7:0];
         s1_id_ff     <= parse.id;
         s1_ok_ff     <= pready_ff;
         s1_last_ff   <= pull_last;
         s1_total_ff  <= total_ff[9:0];
      end
   end

   always_ff @(posedge clock) begin
      if (apply && c_store) begin
         len_ff[s1_idx_ff] <= s1_plen_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s1_valid_ff && (s1_pull_ff || s1_end_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (s1_pull_ff) begin
            rsp_kind_ff   <= frr_pkg::KIND_BYTE;
            rsp_status_ff <= s1_ok_ff ? frr_pkg::ST_COMPLETE : frr_pkg::ST_NO_PACKET;
            rsp_byte_ff   <= s1_ok_ff ? rd_data : 8'd0;
            rsp_len_ff    <= s1_ok_ff ? s1_total_ff : 10'd0;
            rsp_last_ff   <= s1_ok_ff && s1_last_ff;
         end else begin
            rsp_kind_ff   <= frr_pkg::KIND_STATUS;
            rsp_status_ff <= c_status;
            rsp_byte_ff   <= 8'd0;
            rsp_len_ff    <= (c_status == frr_pkg::ST_COMPLETE) ? c_tot[9:0] : 10'd0;
            rsp_last_ff   <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.result_kind   = rsp_kind_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.packet_byte   = rsp_byte_ff;
   assign rsp_chan.packet_length = rsp_len_ff;
   assign rsp_chan.last_byte     = rsp_last_ff;

endmodule
`default_nettype wire

>>> rtl/frr_checker.sv
`default_nettype none
module frr_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_kind,
   input wire logic [2:0] rsp_status,
   input wire logic [7:0] rsp_byte,
   input wire logic [9:0] rsp_len,
   input wire logic       rsp_last
);

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_byte_status : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == frr_pkg::KIND_BYTE |->
         rsp_status == frr_pkg::ST_COMPLETE || rsp_status == frr_pkg::ST_NO_PACKET)
      else $error("byte beat with frame status");

   a_no_packet : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == frr_pkg::ST_NO_PACKET |->
         rsp_byte == 8'd0 && rsp_len == 10'd0 && !rsp_last)
      else $error("no-packet beat carries data");

   a_last_kind : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |->
         rsp_kind == frr_pkg::KIND_BYTE && rsp_status == frr_pkg::ST_COMPLETE)
      else $error("last flag outside a packet byte");

endmodule

bind fragment_frame_reassembler_core frr_checker u_frr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_kind   (rsp_chan.result_kind),
   .rsp_status (rsp_chan.status),
   .rsp_byte   (rsp_chan.packet_byte),
   .rsp_len    (rsp_chan.packet_length),
   .rsp_last   (rsp_chan.last_byte)
);
`default_nettype wire

>>> sim/testbench.sv
`default_nettype none
module testbench;
   import frr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HDR_LEN       = 15;
   localparam int MAX_FRAGS     = 16;
   localparam int MAX_PAYLOAD   = 240;
   localparam int MAX_FRAME     = 255;
   localparam int MTU           = 512;
   localparam int STALL_LIMIT   = 2000;
   localparam int ITEM_TARGET   = 1000;

   // kinds of malformed frame
   typedef enum int {
      BAD_MAGIC_A, BAD_MAGIC_B, BAD_VERSION, BAD_COUNT_ZERO, BAD_COUNT_HIGH,
      BAD_INDEX, BAD_PLEN, BAD_SHORT_BODY, BAD_LONG_BODY, BAD_SHORT_HEADER,
      BAD_OVERSIZE, BAD_KIND_COUNT
   } bad_kind_e;

   typedef struct {
      logic           kind;
      frr_status_type status;
      logic [7:0]     pbyte;
      logic [9:0]     plength;
      logic           last;
   } reasm_result_t;

   logic clock = 1'b0;
   logic reset;
   logic       csr_write_enable;
   logic [9:0] csr_write_data;

   frr_req_if req_chan ();
   frr_rsp_if rsp_chan ();

   fragment_frame_reassembler_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_chan),
      .rsp_chan        (rsp_chan),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   always #0.5 clock = ~clock;

   // ---------------- reassembly predictor state ----------------
   logic [9:0]  buf_size;
   int unsigned parse_pos;
   logic [7:0]  hdr_idx, hdr_cnt;
   logic [15:0] hdr_plen;
   logic [63:0] hdr_id;
   logic [1:0]  hdr_flags;
   logic [7:0]  staging [MAX_PAYLOAD];
   logic        msg_active;
   int unsigned msg_frags;
   logic [63:0] msg_id;
   logic        frag_held [MAX_FRAGS];
   int unsigned frags_held;
   logic [7:0]  frag_mem [MAX_FRAGS][MAX_PAYLOAD];
   int unsigned frag_len [MAX_FRAGS];
   logic [9:0]  read_ptr;
   logic        pkt_ready;

   reasm_result_t results_due[$];
   int  errors;
   int  items_sent;
   bit  quiet;
   int  idle_cycles;

   logic [7:0] frame_buf[$];
   logic [7:0] frag_data[MAX_FRAGS][$];

   function automatic void expect_result(logic k, frr_status_type s, logic [7:0] b,
                                         logic [9:0] l, logic lb);
      reasm_result_t r;
      r.kind = k; r.status = s; r.pbyte = b; r.plength = l; r.last = lb;
      results_due.push_back(r);
   endfunction

   function automatic void clear_parser();
      parse_pos = 0; hdr_idx = '0; hdr_cnt = '0; hdr_plen = '0; hdr_id = '0; hdr_flags = '0;
   endfunction

   function automatic void reset_reassembly();
      buf_size = 10'd512;
      clear_parser();
      msg_active = 1'b0; msg_frags = 0; msg_id = '0; frags_held = 0;
      foreach (frag_held[i]) frag_held[i] = 1'b0;
      read_ptr = '0; pkt_ready = 1'b0;
   endfunction

   function automatic int unsigned joined_length();
      int unsigned t;
      t = 0;
      for (int i = 0; i < msg_frags && i < MAX_FRAGS; i++) t += frag_len[i];
      return t;
   endfunction

   function automatic void capture_byte(logic [7:0] b);
      if (parse_pos >= MAX_FRAME) begin
         hdr_flags[1] = 1'b1;
         return;
      end
      if ((parse_pos == POS_MAGIC_A && b != MAGIC_A) ||
          (parse_pos == POS_MAGIC_B && b != MAGIC_B) ||
          (parse_pos == POS_VERSION && b != FRAME_VERSION))
         hdr_flags[0] = 1'b1;
      else if (parse_pos == POS_INDEX)  hdr_idx = b;
      else if (parse_pos == POS_COUNT)  hdr_cnt = b;
      else if (parse_pos == POS_LEN_HI) hdr_plen[15:8] = b;
      else if (parse_pos == POS_LEN_LO) hdr_plen[7:0] = b;
      else if (parse_pos < HDR_LEN)     hdr_id = {hdr_id[55:0], b};
      else if (parse_pos - HDR_LEN < MAX_PAYLOAD) staging[parse_pos - HDR_LEN] = b;
      parse_pos++;
   endfunction

   function automatic void commit_frame();
      int unsigned total;
      bit differs;
      if (hdr_flags != 0 || parse_pos < HDR_LEN || hdr_cnt == 0 || hdr_cnt > MAX_FRAGS ||
          hdr_idx >= hdr_cnt || hdr_plen > MAX_PAYLOAD || parse_pos != HDR_LEN + hdr_plen) begin
         expect_result(KIND_STATUS, ST_BAD_FRAME, '0, '0, 1'b0);
         return;
      end
      if (!(msg_active && msg_frags == hdr_cnt && msg_id == hdr_id)) begin
         foreach (frag_held[i]) frag_held[i] = 1'b0;
         frags_held = 0; msg_active = 1'b1; msg_frags = hdr_cnt; msg_id = hdr_id;
         pkt_ready = 1'b0; read_ptr = '0;
      end
      if (frag_held[hdr_idx]) begin
         differs = frag_len[hdr_idx] != hdr_plen;
         for (int k = 0; k < hdr_plen && !differs; k++)
            if (frag_mem[hdr_idx][k] != staging[k]) differs = 1'b1;
         if (differs) begin
            expect_result(KIND_STATUS, ST_DUP_MISMATCH, '0, '0, 1'b0);
            return;
         end
      end else begin
         for (int k = 0; k < hdr_plen; k++) frag_mem[hdr_idx][k] = staging[k];
         frag_len[hdr_idx] = hdr_plen;
         frag_held[hdr_idx] = 1'b1;
         frags_held++;
      end
      if (frags_held != msg_frags) begin
         expect_result(KIND_STATUS, ST_STORED, '0, '0, 1'b0);
         return;
      end
      total = joined_length();
      if (total > MTU || total > buf_size) begin
         pkt_ready = 1'b0;
         expect_result(KIND_STATUS, ST_TOO_LARGE, '0, '0, 1'b0);
         return;
      end
      pkt_ready = total > 0;
      read_ptr = '0;
      expect_result(KIND_STATUS, ST_COMPLETE, '0, total[9:0], 1'b0);
   endfunction

   function automatic void pull_packet_byte();
      int unsigned total, ptr;
      logic [7:0] b;
      logic lb;
      if (!pkt_ready) begin
         expect_result(KIND_BYTE, ST_NO_PACKET, '0, '0, 1'b0);
         return;
      end
      total = joined_length();
      ptr = read_ptr;
      b = '0;
      for (int i = 0; i < msg_frags && i < MAX_FRAGS; i++) begin
         if (ptr < frag_len[i]) begin
            b = frag_mem[i][ptr];
            break;
         end
         ptr -= frag_len[i];
      end
      lb = (int'(read_ptr) + 1) >= total;
      expect_result(KIND_BYTE, ST_COMPLETE, b, total[9:0], lb);
      read_ptr = read_ptr + 10'd1;
      if (lb) pkt_ready = 1'b0;
   endfunction

   function automatic void predict_beat(logic op, logic [7:0] b, logic fe);
      if (op == OP_PULL) begin
         pull_packet_byte();
         return;
      end
      capture_byte(b);
      if (!fe) return;
      commit_frame();
      clear_parser();
   endfunction

   // ---------------- request side ----------------
   // called at a rising edge; returns at the edge the beat is accepted
   task automatic send_beat(logic op, logic [7:0] b, logic fe);
      int gap;
      if (!quiet && $urandom_range(0, 11) == 0) begin
         gap = $urandom_range(1, 17);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.operation <= op;
      req_chan.data_byte <= b;
      req_chan.frame_end <= fe;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_beat(op, b, fe);
      items_sent++;
   endtask

   task automatic send_frame_buf();
      for (int i = 0; i < frame_buf.size(); i++)
         send_beat(OP_FRAME, frame_buf[i], i == frame_buf.size() - 1);
   endtask

   function automatic void build_header(logic [7:0] idx, logic [7:0] cnt, logic [15:0] plen,
                                        logic [63:0] id);
      frame_buf = {MAGIC_A, MAGIC_B, FRAME_VERSION, idx, cnt, plen[15:8], plen[7:0]};
      for (int i = 7; i >= 0; i--) frame_buf.push_back(id[i*8 +: 8]);
   endfunction

   task automatic send_pulls(int n);
      repeat (n) send_beat(OP_PULL, 8'($urandom), 1'($urandom));
   endtask

   // hold the sender and let every due result drain
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (results_due.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_buffer_size(logic [9:0] v);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      buf_size = v;
   endtask

   // send fragment i of the message held in frag_data; mutate forces a repeat mismatch
   task automatic send_fragment(int i, int cnt, logic [63:0] id, bit mutate);
      int n, pos;
      n = frag_data[i].size();
      if (mutate && n == 0) begin
         build_header(i, cnt, 1, id);
         frame_buf.push_back(8'($urandom));
      end else begin
         build_header(i, cnt, n, id);
         foreach (frag_data[i][k]) frame_buf.push_back(frag_data[i][k]);
         if (mutate) begin
            pos = HDR_LEN + $urandom_range(0, n - 1);
            frame_buf[pos] = frame_buf[pos] ^ 8'($urandom_range(1, 255));
         end
      end
      send_frame_buf();
   endtask

   task automatic send_bad_frame(bad_kind_e kind);
      logic [7:0] cnt, idx;
      int plen;
      cnt = $urandom_range(1, MAX_FRAGS);
      idx = $urandom_range(0, cnt - 1);
      plen = $urandom_range(0, 6);
      case (kind)
         BAD_COUNT_ZERO: cnt = 8'd0;
         BAD_COUNT_HIGH: cnt = $urandom_range(MAX_FRAGS + 1, 255);
         BAD_INDEX: idx = $urandom_range(cnt, 255);
         BAD_OVERSIZE: plen = MAX_PAYLOAD;
         default: ;
      endcase
      build_header(idx, cnt, kind == BAD_PLEN ? 16'($urandom_range(MAX_PAYLOAD + 1, 65535))
                                              : 16'(plen), {$urandom, $urandom});
      case (kind)
         BAD_MAGIC_A: frame_buf[0] = 8'($urandom_range(0, 255)) | 8'h80;
         BAD_MAGIC_B: frame_buf[1] = MAGIC_B ^ 8'($urandom_range(1, 255));
         BAD_VERSION: frame_buf[2] = FRAME_VERSION ^ 8'($urandom_range(1, 255));
         default: ;
      endcase
      if (kind == BAD_SHORT_BODY) plen = plen + 1;
      else if (kind == BAD_LONG_BODY && plen > 0) plen = plen - 1;
      else if (kind == BAD_LONG_BODY) frame_buf.delete(HDR_LEN - 1);
      if (kind == BAD_SHORT_HEADER) frame_buf = frame_buf[0:$urandom_range(0, HDR_LEN - 2)];
      else if (kind == BAD_OVERSIZE)
         repeat ($urandom_range(MAX_FRAME - HDR_LEN + 1, 300)) frame_buf.push_back(8'($urandom));
      else if (kind == BAD_SHORT_BODY)
         repeat (plen - 1) frame_buf.push_back(8'($urandom));
      else if (kind == BAD_LONG_BODY)
         repeat (plen + 1) frame_buf.push_back(8'($urandom));
      else repeat (plen) frame_buf.push_back(8'($urandom));
      send_frame_buf();
   endtask

   // one message: fragments shuffled, with repeats, noise and early abandon, then pulls
   task automatic run_message(int cnt, int max_len);
      logic [63:0] id;
      int order[$];
      int total, j, tmp, stop_at;
      id = {$urandom, $urandom};
      total = 0;
      for (int i = 0; i < cnt; i++) begin
         frag_data[i].delete();
         repeat ($urandom_range(0, max_len)) frag_data[i].push_back(8'($urandom));
         total += frag_data[i].size();
         order.push_back(i);
      end
      for (int i = cnt - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = order[i]; order[i] = order[j]; order[j] = tmp;
      end
      stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, cnt - 1) : cnt;
      for (int k = 0; k < stop_at; k++) begin
         send_fragment(order[k], cnt, id, 1'b0);
         if ($urandom_range(0, 5) == 0)
            send_fragment(order[$urandom_range(0, k)], cnt, id, $urandom_range(0, 1));
         if ($urandom_range(0, 9) == 0)
            send_bad_frame(bad_kind_e'($urandom_range(0, BAD_KIND_COUNT - 1)));
      end
      send_pulls((total > MTU ? 4 : total) + $urandom_range(0, 2));
   endtask

   // ---------------- tests ----------------
   task automatic test_pull_when_empty();
      send_pulls(2);
   endtask

   task automatic test_single_fragments();
      build_header(0, 1, 0, 64'hffff_ffff_ffff_ffff);
      send_frame_buf();
      send_pulls(1);
      build_header(0, 1, 3, 64'h0);
      frame_buf.push_back(8'h00); frame_buf.push_back(8'hff); frame_buf.push_back(8'h5a);
      send_frame_buf();
      send_pulls(4);
   endtask

   task automatic test_malformed_frames();
      for (int k = 0; k < BAD_KIND_COUNT; k++) send_bad_frame(bad_kind_e'(k));
   endtask

   task automatic test_buffer_limits();
      write_buffer_size(10'd0);
      run_message(1, 3);
      write_buffer_size(10'd512);
      run_message(3, MAX_PAYLOAD);
      frag_data[0].delete();
      build_header(1, 2, MAX_PAYLOAD, 64'h1234);
      repeat (MAX_PAYLOAD) frame_buf.push_back(8'($urandom));
      send_frame_buf();
      build_header(0, 2, MAX_PAYLOAD, 64'h1234);
      repeat (MAX_PAYLOAD) frame_buf.push_back(8'($urandom));
      send_frame_buf();
      send_pulls(2 * MAX_PAYLOAD + 1);
      write_buffer_size(10'($urandom_range(1, 40)));
      run_message(4, 20);
   endtask

   task automatic test_random_traffic();
      int next_cfg;
      next_cfg = items_sent + 200;
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= next_cfg) begin
            case ($urandom_range(0, 2))
               0: write_buffer_size(10'd512);
               1: write_buffer_size(10'($urandom_range(0, 512)));
               default: write_buffer_size(10'($urandom_range(0, 60)));
            endcase
            next_cfg = items_sent + 200;
         end
         if ($urandom_range(0, 11) == 0) run_message($urandom_range(1, MAX_FRAGS), MAX_PAYLOAD);
         else if ($urandom_range(0, 7) == 0)
            send_bad_frame(bad_kind_e'($urandom_range(0, BAD_KIND_COUNT - 1)));
         else run_message($urandom_range(1, 5), 12);
      end
   endtask

   task automatic test_steady_tail();
      write_buffer_size(10'd512);
      quiet = 1'b1;
      repeat (4) run_message($urandom_range(1, 4), 10);
   endtask

   // ---------------- result side ----------------
   int stall_left;
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_chan.ready <= 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 16);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   function automatic void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      reasm_result_t r;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (results_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual kind %0d status %0d",
                     $time, rsp_chan.result_kind, rsp_chan.status);
         end else begin
            r = results_due.pop_front();
            compare_field("result_kind", r.kind, rsp_chan.result_kind);
            compare_field("status", r.status, rsp_chan.status);
            compare_field("packet_byte", r.pbyte, rsp_chan.packet_byte);
            compare_field("packet_length", r.plength, rsp_chan.packet_length);
            compare_field("last_byte", r.last, rsp_chan.last_byte);
         end
      end
   end

   // count cycles with no beat moving on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      errors = 0;
      items_sent = 0;
      quiet = 1'b0;
      idle_cycles = 0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.operation = OP_FRAME;
      req_chan.data_byte = '0;
      req_chan.frame_end = 1'b0;
      rsp_chan.ready = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      reset_reassembly();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_pull_when_empty();
      test_single_fragments();
      test_malformed_frames();
      test_buffer_limits();
      test_random_traffic();
      test_steady_tail();
      drain();
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
`default_nettype wire
